### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_CLK_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_CLK_ANY(lbl, clk, prop, msg)
`endif
`endif

### hw/rtl/bfha_pkg.sv
package bfha_pkg;
    localparam int AddrBits   = 16;
    localparam int LenBits    = AddrBits + 1;
    localparam int MaxBlocks  = 64;
    localparam int SlotBits   = $clog2(MaxBlocks);
    localparam int HeaderBytes = 4;

    localparam logic [2:0] StOk      = 3'd0;
    localparam logic [2:0] StLimit   = 3'd1;
    localparam logic [2:0] StNofit   = 3'd2;
    localparam logic [2:0] StUnknown = 3'd3;
    localparam logic [2:0] StFull    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_FSCAN, S_FWAIT, S_ALLOC_WR,
        S_USCAN, S_UWAIT, S_FREE_WR1, S_FREE_WR2, S_DONE
    } t_state;

    // Free table entry
    typedef struct packed {
        logic [AddrBits-1:0] start;
        logic [LenBits-1:0]  length;
    } t_free_ent;

    // Used table entry
    typedef struct packed {
        logic [AddrBits-1:0] start;
        logic [LenBits-1:0]  length;
    } t_used_ent;

    // Memory port bundle
    typedef struct packed {
        logic                 we;
        logic [SlotBits-1:0]  waddr;
        logic [AddrBits+LenBits-1:0] wdata;
        logic [SlotBits-1:0]  raddr;
    } t_mem_req;
endpackage

### hw/rtl/bfha_ram.sv
module bfha_ram #(
    parameter int Width = 33,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hw/rtl/best_fit_heap_allocator.sv
// Best-fit heap allocator. Free regions and used blocks live in two 64-entry
// synchronous RAMs with valid bits in flip-flops. Each request walks the
// tables one slot per cycle through each RAM's single read port: an allocate
// makes one free-table scan, a free a used-table search and then a neighbour
// scan of the free table; a refused allocate or an unknown address ends
// sooner. One request is in work at a time. The result is copied into an
// output register, so the next request is taken while it waits; a finished
// request holds in its last state only while an earlier result is still
// stalled there.
`include "assert_macros.svh"
module best_fit_heap_allocator import bfha_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_kind,
    input  logic [LenBits-1:0]  i_request_size,
    input  logic [AddrBits-1:0] i_block_address,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_status,
    output logic [AddrBits-1:0] o_user_address,
    output logic [LenBits-1:0]  o_allocated_bytes,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [LenBits-1:0]  i_cfg_data
);
    localparam int Ew = AddrBits + LenBits;
    localparam logic [LenBits-1:0] HeapBytes = LenBits'(1) << AddrBits;
    localparam logic [SlotBits-1:0] LastSlot = SlotBits'(MaxBlocks - 1);

    t_state r_state, n_state;
    logic [LenBits-1:0] r_limit, r_total, n_total;
    logic [MaxBlocks-1:0] r_fvalid, n_fvalid, r_uvalid, n_uvalid;
    logic r_kind;
    logic [LenBits:0] r_need;
    logic [AddrBits-1:0] r_addr;
    logic [SlotBits-1:0] r_idx, n_idx;
    // scan results
    logic r_best_ok, n_best_ok, r_exact, n_exact;
    logic [SlotBits-1:0] r_best, n_best;
    logic [LenBits-1:0] r_best_len, n_best_len;
    logic [AddrBits-1:0] r_best_start, n_best_start;
    logic r_bef_ok, n_bef_ok, r_aft_ok, n_aft_ok;
    logic [SlotBits-1:0] r_bef, n_bef, r_aft, n_aft;
    logic [LenBits-1:0] r_bef_len, n_bef_len, r_aft_len, n_aft_len;
    logic r_u_ok, n_u_ok;
    logic [SlotBits-1:0] r_u, n_u;
    logic [AddrBits-1:0] r_ustart, n_ustart;
    logic [LenBits-1:0] r_ulen, n_ulen;
    logic r_ov, n_ov;
    logic [2:0] r_st, n_st;
    logic [AddrBits-1:0] r_ua, n_ua;
    // output register
    logic [2:0] r_o_st;
    logic [AddrBits-1:0] r_o_ua;
    logic [LenBits-1:0] r_o_total;
    logic done_go;

    t_mem_req fq, uq;
    logic [Ew-1:0] f_rd, u_rd;
    t_free_ent fe;
    t_used_ent ue;
    logic [MaxBlocks-1:0] fv_eff;
    logic [SlotBits-1:0] f_empty, u_empty;
    logic f_has_empty, u_has_empty;

    bfha_ram #(.Width(Ew), .Depth(MaxBlocks)) u_free (
        .i_clk(i_clk), .i_we(fq.we), .i_waddr(fq.waddr), .i_wdata(fq.wdata),
        .i_raddr(fq.raddr), .o_rdata(f_rd));
    bfha_ram #(.Width(Ew), .Depth(MaxBlocks)) u_used (
        .i_clk(i_clk), .i_we(uq.we), .i_waddr(uq.waddr), .i_wdata(uq.wdata),
        .i_raddr(uq.raddr), .o_rdata(u_rd));

    // Slot 0 reads as the whole heap until first written; its data is
    // examined when r_idx has moved on to slot 1
    logic r_f0_init;
    assign fe = (r_f0_init && r_idx == SlotBits'(1)) ? t_free_ent'{'0, HeapBytes}
                                                    : t_free_ent'(f_rd);
    assign ue = t_used_ent'(u_rd);
    assign fv_eff = r_fvalid;

    // Priority encoders for first empty slot
    always_comb begin
        f_empty = '0; f_has_empty = 1'b0;
        u_empty = '0; u_has_empty = 1'b0;
        for (int i = MaxBlocks - 1; i >= 0; i--) begin
            if (!r_fvalid[i]) begin f_empty = SlotBits'(i); f_has_empty = 1'b1; end
            if (!r_uvalid[i]) begin u_empty = SlotBits'(i); u_has_empty = 1'b1; end
        end
    end

    assign done_go = (r_state == S_DONE) && !(r_ov && i_stall);
    assign o_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_ov;
    assign o_status = r_o_st;
    assign o_user_address = r_o_ua;
    assign o_allocated_bytes = r_o_total;

    logic [LenBits:0] ext_len, blk_end;
    logic [AddrBits:0] fe_end;
    always_comb begin
        ext_len = {1'b0, fe.length};
        fe_end = {1'b0, fe.start} + fe.length[AddrBits:0];
        blk_end = {1'b0, r_ustart} + r_ulen;
    end

    // Next state and memory control
    always_comb begin
        n_state = r_state; n_total = r_total; n_fvalid = r_fvalid; n_uvalid = r_uvalid;
        n_idx = r_idx;
        n_best_ok = r_best_ok; n_exact = r_exact; n_best = r_best;
        n_best_len = r_best_len; n_best_start = r_best_start;
        n_bef_ok = r_bef_ok; n_aft_ok = r_aft_ok; n_bef = r_bef; n_aft = r_aft;
        n_bef_len = r_bef_len; n_aft_len = r_aft_len;
        n_u_ok = r_u_ok; n_u = r_u; n_ustart = r_ustart; n_ulen = r_ulen;
        n_ov = r_ov && i_stall; n_st = r_st; n_ua = r_ua;
        fq = '0; uq = '0;
        fq.raddr = r_idx; uq.raddr = r_idx;
        unique case (r_state)
            S_IDLE: begin
                n_idx = '0;
                if (i_valid && !o_stall) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_best_ok = 1'b0; n_exact = 1'b0; n_bef_ok = 1'b0; n_aft_ok = 1'b0;
                n_u_ok = 1'b0; n_idx = SlotBits'(1);
                n_ua = '0;
                if (!r_kind) begin
                    if ({1'b0, r_total} + r_need > {1'b0, r_limit}) begin
                        n_st = StLimit; n_state = S_DONE;
                    end else if (!u_has_empty) begin
                        n_st = StFull; n_state = S_DONE;
                    end else n_state = S_FSCAN;
                end else n_state = S_USCAN;
            end
            // Free table scan: read issued at r_idx-1 last cycle
            S_FSCAN, S_FWAIT: begin
                if (!r_kind) begin
                    if (fv_eff[r_idx - SlotBits'(1)] && !r_exact) begin
                        if (ext_len == r_need) begin
                            n_exact = 1'b1; n_best_ok = 1'b1; n_best = r_idx - SlotBits'(1);
                            n_best_len = fe.length; n_best_start = fe.start;
                        end else if (ext_len > r_need && (!r_best_ok || r_best_len > fe.length)) begin
                            n_best_ok = 1'b1; n_best = r_idx - SlotBits'(1);
                            n_best_len = fe.length; n_best_start = fe.start;
                        end
                    end
                end else if (fv_eff[r_idx - SlotBits'(1)]) begin
                    if ({1'b0, fe_end} == {1'b0, r_ustart}) begin
                        if (!r_bef_ok) begin
                            n_bef_ok = 1'b1; n_bef = r_idx - SlotBits'(1); n_bef_len = fe.length;
                        end
                    end else if ({1'b0, fe.start} == blk_end && !r_aft_ok) begin
                        n_aft_ok = 1'b1; n_aft = r_idx - SlotBits'(1); n_aft_len = fe.length;
                    end
                end
                if (r_state == S_FWAIT)
                    n_state = r_kind ? S_FREE_WR1 : S_ALLOC_WR;
                else begin
                    n_idx = r_idx + SlotBits'(1);
                    if (r_idx == LastSlot) n_state = S_FWAIT;
                    fq.raddr = r_idx;
                end
            end
            S_ALLOC_WR: begin
                if (!r_best_ok) begin
                    n_st = StNofit;
                end else begin
                    n_st = StOk;
                    fq.waddr = r_best;
                    if (r_exact) n_fvalid[r_best] = 1'b0;
                    else begin
                        fq.we = 1'b1;
                        fq.wdata = {r_best_start + r_need[AddrBits-1:0],
                                    r_best_len - r_need[LenBits-1:0]};
                    end
                    uq.we = 1'b1; uq.waddr = u_empty;
                    uq.wdata = {r_best_start, r_need[LenBits-1:0]};
                    n_uvalid[u_empty] = 1'b1;
                    n_total = r_total + r_need[LenBits-1:0];
                    n_ua = r_best_start + AddrBits'(HeaderBytes);
                end
                n_state = S_DONE;
            end
            // Used table search for the lowest matching slot
            S_USCAN, S_UWAIT: begin
                if (!r_u_ok && r_uvalid[r_idx - SlotBits'(1)] &&
                    ue.start + AddrBits'(HeaderBytes) == r_addr) begin
                    n_u_ok = 1'b1; n_u = r_idx - SlotBits'(1);
                    n_ustart = ue.start; n_ulen = ue.length;
                end
                if (r_state == S_UWAIT) begin
                    n_idx = SlotBits'(1);
                    fq.raddr = '0;
                    if (n_u_ok) n_state = S_FSCAN;
                    else begin n_st = StUnknown; n_state = S_DONE; end
                end else begin
                    n_idx = r_idx + SlotBits'(1);
                    if (r_idx == LastSlot) n_state = S_UWAIT;
                    uq.raddr = r_idx;
                end
            end
            S_FREE_WR1: begin
                n_st = StOk;
                if (!r_bef_ok && !r_aft_ok) begin
                    if (!f_has_empty) n_st = StFull;
                    else begin
                        fq.we = 1'b1; fq.waddr = f_empty;
                        fq.wdata = {r_ustart, r_ulen};
                        n_fvalid[f_empty] = 1'b1;
                    end
                end else if (r_bef_ok) begin
                    fq.we = 1'b1; fq.waddr = r_bef;
                    fq.raddr = r_bef;
                    fq.wdata = {r_ustart - r_bef_len[AddrBits-1:0],
                                r_bef_len + r_ulen + (r_aft_ok ? r_aft_len : '0)};
                    if (r_aft_ok) n_fvalid[r_aft] = 1'b0;
                end else begin
                    fq.we = 1'b1; fq.waddr = r_aft;
                    fq.wdata = {r_ustart, r_aft_len + r_ulen};
                end
                if (n_st == StOk) begin
                    n_uvalid[r_u] = 1'b0;
                    n_total = (r_total >= r_ulen) ? r_total - r_ulen : '0;
                end
                n_state = S_FREE_WR2;
            end
            S_FREE_WR2: n_state = S_DONE;
            // Hold until the output register is free
            S_DONE: begin
                if (done_go) begin
                    n_ov = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state, limit, total and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_limit <= HeapBytes; r_total <= '0;
            r_fvalid <= MaxBlocks'(1); r_uvalid <= '0; r_ov <= 1'b0; r_f0_init <= 1'b1;
        end else begin
            r_state <= n_state; r_total <= n_total; r_fvalid <= n_fvalid;
            r_uvalid <= n_uvalid; r_ov <= n_ov;
            if (fq.we && fq.waddr == '0) r_f0_init <= 1'b0;
            if (i_cfg_valid) r_limit <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && !o_stall) begin
            r_kind <= i_kind;
            r_need <= {1'b0, i_request_size} + (LenBits+1)'(HeaderBytes);
            r_addr <= i_block_address;
        end
        r_idx <= n_idx;
        r_best_ok <= n_best_ok; r_exact <= n_exact; r_best <= n_best;
        r_best_len <= n_best_len; r_best_start <= n_best_start;
        r_bef_ok <= n_bef_ok; r_aft_ok <= n_aft_ok; r_bef <= n_bef; r_aft <= n_aft;
        r_bef_len <= n_bef_len; r_aft_len <= n_aft_len;
        r_u_ok <= n_u_ok; r_u <= n_u; r_ustart <= n_ustart; r_ulen <= n_ulen;
        r_st <= n_st; r_ua <= n_ua;
        // Load the finished result into the output register
        if (done_go) begin
            r_o_st <= r_st; r_o_ua <= r_ua; r_o_total <= r_total;
        end
    end

    `ASSERT_CLK(a_total_le_heap, i_clk, i_rst_n, r_total <= HeapBytes, "total above heap")
    `ASSERT_CLK(a_no_accept_busy, i_clk, i_rst_n, (r_state != S_IDLE) |-> o_stall, "accept while busy")
    `ASSERT_CLK(a_done_valid, i_clk, i_rst_n, (r_state == S_DONE) |=> o_valid, "result lost")
    `ASSERT_CLK(a_ok_alloc_addr, i_clk, i_rst_n,
        (r_state == S_ALLOC_WR && !r_best_ok) |=> (r_ua == '0), "addr on refusal")
endmodule

### test/testbench.sv
`timescale 1ns / 100ps
module testbench import bfha_pkg::*;;

    typedef struct packed {
        logic                kind;
        logic [LenBits-1:0]  size;
        logic [AddrBits-1:0] addr;
    } t_request;

    typedef struct packed {
        logic [2:0]          status;
        logic [AddrBits-1:0] uaddr;
        logic [LenBits-1:0]  total;
    } t_answer;

    localparam logic KindAlloc = 1'b0;
    localparam logic KindFree  = 1'b1;
    localparam int   CycleLimit = 3000000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic                i_kind = 1'b0;
    logic [LenBits-1:0]  i_request_size = '0;
    logic [AddrBits-1:0] i_block_address = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [2:0]          o_status;
    logic [AddrBits-1:0] o_user_address;
    logic [LenBits-1:0]  o_allocated_bytes;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [LenBits-1:0]  i_cfg_data = '0;

    best_fit_heap_allocator dut (.*);

    always #2 i_clk = ~i_clk;

    // allocator shadow state
    logic [LenBits-1:0]  lim;
    logic [AddrBits-1:0] fs [MaxBlocks];
    logic [LenBits-1:0]  fl [MaxBlocks];
    logic                fv [MaxBlocks];
    logic [AddrBits-1:0] us [MaxBlocks];
    logic [LenBits-1:0]  ul [MaxBlocks];
    logic                uv [MaxBlocks];
    logic [LenBits-1:0]  total;

    t_request pending[$];
    t_answer  expected_answers[$];
    logic [AddrBits-1:0] live_addrs[$];
    int errors = 0;
    int accepted = 0;
    int answered = 0;
    int cycles = 0;
    bit hold_off = 0;
    bit in_fire = 0;
    bit out_fire = 0;

    function automatic void shadow_reset();
        for (int i = 0; i < MaxBlocks; i++) begin
            fs[i] = '0; fl[i] = '0; fv[i] = 0; us[i] = '0; ul[i] = '0; uv[i] = 0;
        end
        fl[0] = 17'h10000;
        fv[0] = 1;
        total = '0;
        lim = 17'h10000;
    endfunction

    function automatic t_answer predict_request(t_request r);
        t_answer a;
        logic [17:0] need;
        logic [18:0] sum;
        logic [16:0] st;
        logic [17:0] bend;
        int best, slot, u, bef, aft, s;
        a.uaddr = '0;
        best = -1; slot = -1; u = -1; bef = -1; aft = -1; s = -1;
        if (r.kind == KindAlloc) begin
            need = 18'(r.size) + 18'(HeaderBytes);
            sum = 19'(total) + 19'(need);
            if (sum > 19'(lim)) a.status = StLimit;
            else begin
                for (int i = 0; i < MaxBlocks; i++)
                    if (!uv[i] && slot < 0) slot = i;
                if (slot < 0) a.status = StFull;
                else begin
                    for (int i = 0; i < MaxBlocks; i++) begin
                        if (!fv[i]) continue;
                        if (fl[i] == need) begin best = i; break; end
                        if (fl[i] > need && (best < 0 || fl[best] > fl[i])) best = i;
                    end
                    if (best < 0) a.status = StNofit;
                    else begin
                        st = 17'(fs[best]);
                        if (fl[best] == need) fv[best] = 0;
                        else begin
                            fs[best] = AddrBits'(18'(st) + need);
                            fl[best] = LenBits'(18'(fl[best]) - need);
                        end
                        us[slot] = AddrBits'(st); ul[slot] = LenBits'(need); uv[slot] = 1;
                        total = sum[16:0];
                        a.uaddr = AddrBits'(st + 17'(HeaderBytes));
                        a.status = StOk;
                    end
                end
            end
        end else begin
            for (int i = 0; i < MaxBlocks; i++)
                if (uv[i] && AddrBits'(us[i] + HeaderBytes) == r.addr && u < 0) u = i;
            if (u < 0) a.status = StUnknown;
            else begin
                bend = 18'(us[u]) + 18'(ul[u]);
                for (int i = 0; i < MaxBlocks; i++) begin
                    if (!fv[i]) continue;
                    if (18'(fs[i] + fl[i]) == 18'(us[u])) begin
                        if (bef < 0) bef = i;
                    end else if (18'(fs[i]) == bend) begin
                        if (aft < 0) aft = i;
                    end
                end
                a.status = StOk;
                if (bef < 0 && aft < 0) begin
                    for (int i = 0; i < MaxBlocks; i++)
                        if (!fv[i] && s < 0) s = i;
                    if (s < 0) a.status = StFull;
                    else begin fs[s] = us[u]; fl[s] = ul[u]; fv[s] = 1; end
                end else if (bef >= 0 && aft >= 0) begin
                    fl[bef] = fl[bef] + ul[u] + fl[aft];
                    fv[aft] = 0;
                end else if (bef >= 0) fl[bef] = fl[bef] + ul[u];
                else begin fs[aft] = us[u]; fl[aft] = fl[aft] + ul[u]; end
                if (a.status == StOk) begin
                    uv[u] = 0;
                    total = (total >= ul[u]) ? total - ul[u] : '0;
                end
            end
        end
        a.total = total;
        return a;
    endfunction

    // drive requests from the pending queue, stall results
    int gap = 0;
    int out_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) begin
                void'(pending.pop_front());
                gap = $urandom_range(0, 12);
                if ($urandom_range(0, 3) == 0) gap = 0;
            end
            if (i_valid && !in_fire) begin
            end else if (gap > 0 || hold_off || pending.size() == 0) begin
                if (gap > 0) gap--;
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_kind <= pending[0].kind;
                i_request_size <= pending[0].size;
                i_block_address <= pending[0].addr;
            end
            if (out_fire) out_gap = $urandom_range(0, 12);
            if (o_valid && out_gap > 0) begin
                out_gap--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // predict on accept, check results
    always @(posedge i_clk) begin
        t_request r;
        t_answer e;
        if (i_rst_n) begin
            cycles++;
            in_fire = i_valid && !o_stall;
            out_fire = o_valid && !i_stall;
            if (in_fire) begin
                r = '{i_kind, i_request_size, i_block_address};
                e = predict_request(r);
                if (r.kind == KindAlloc && e.status == StOk) live_addrs.push_back(e.uaddr);
                expected_answers.push_back(e);
                accepted++;
            end
            if (out_fire) begin
                answered++;
                if (expected_answers.size() == 0) begin
                    $error("unexpected result status=%0d", o_status);
                    errors++;
                end else begin
                    e = expected_answers.pop_front();
                    if (o_status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, o_status); errors++;
                    end
                    if (o_user_address !== e.uaddr) begin
                        $error("user_address exp %0h got %0h", e.uaddr, o_user_address);
                        errors++;
                    end
                    if (o_allocated_bytes !== e.total) begin
                        $error("allocated_bytes exp %0h got %0h", e.total,
                               o_allocated_bytes);
                        errors++;
                    end
                end
            end
            if (cycles > CycleLimit) begin
                $display("best_fit_heap_allocator regression: fail");
                $finish;
            end
        end
    end

    task automatic push_req(logic k, logic [LenBits-1:0] sz, logic [AddrBits-1:0] ad);
        t_request r;
        r.kind = k; r.size = sz; r.addr = ad;
        pending.push_back(r);
    endtask

    // wait until everything queued has been answered
    task automatic drain();
        while (pending.size() != 0 || expected_answers.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [LenBits-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        lim = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [AddrBits-1:0] pick_addr();
        int k;
        if (live_addrs.size() == 0 || $urandom_range(0, 9) == 0) return AddrBits'($urandom);
        k = $urandom_range(0, live_addrs.size() - 1);
        pick_addr = live_addrs[k];
        live_addrs.delete(k);
    endfunction

    // random phase: mostly small allocs and frees of live blocks
    task automatic random_phase(int n);
        logic [LenBits-1:0] sz;
        for (int i = 0; i < n; i++) begin
            while (pending.size() > 4) @(posedge i_clk);
            if ($urandom_range(0, 1)) push_req(KindFree, LenBits'($urandom), pick_addr());
            else begin
                case ($urandom_range(0, 9))
                    0: sz = LenBits'($urandom);
                    1: sz = LenBits'(17'h10000 - $urandom_range(0, 8));
                    default: sz = LenBits'($urandom_range(0, 600));
                endcase
                push_req(KindAlloc, sz, AddrBits'($urandom));
            end
        end
    endtask

    initial begin
        shadow_reset();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, exact fit, coalescing, unknown address
        push_req(KindAlloc, 17'h1FFFF, 16'hFFFF);
        push_req(KindAlloc, 17'h0FFFC, '0);
        push_req(KindFree, '0, 16'h0004);
        push_req(KindFree, '0, 16'h0004);
        push_req(KindAlloc, 17'd0, '0);
        push_req(KindAlloc, 17'd12, '0);
        push_req(KindAlloc, 17'd100, '0);
        push_req(KindFree, '0, 16'h0008);
        push_req(KindAlloc, 17'd12, '0);
        push_req(KindFree, '0, 16'h0008);
        push_req(KindFree, '0, 16'h0004);
        push_req(KindFree, '0, 16'h0018);
        push_req(KindFree, 17'h1FFFF, 16'hFFFF);
        drain();
        live_addrs.delete();

        write_limit(17'd0);
        push_req(KindAlloc, 17'd0, '0);
        drain();
        write_limit(17'd5000);
        random_phase(150);
        drain();

        // fill the used table: tiny allocs, then free every other block
        write_limit(17'h1FFFF);
        for (int i = 0; i < 70; i++) push_req(KindAlloc, 17'd1, '0);
        drain();
        for (int i = 0; i < 32; i++) begin
            push_req(KindFree, '0, 16'(4 + 10 * i));
        end
        drain();
        hold_off = 1;
        repeat (20) @(posedge i_clk);
        hold_off = 0;
        live_addrs.delete();
        for (int i = 0; i < 64; i++) live_addrs.push_back(16'(4 + 5 * i));
        random_phase(200);
        drain();

        write_limit(17'h10000);
        random_phase(300);
        drain();
        $display("ran %0d requests, %0d results, heap limits 0 to max, table full paths",
                 accepted, answered);
        if (errors == 0 && expected_answers.size() == 0)
            $display("best_fit_heap_allocator regression: pass");
        else
            $display("best_fit_heap_allocator regression: fail");
        $finish;
    end

endmodule
